@@ hdl/isq_pkg.sv @@
// shared types and codes for the indexed sequence store
// no dependencies; used by isq_cell and indexed_sequence_store_top
package isq_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_POP_BACK   = 3'd1,
    ACT_PUSH_FRONT = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_INSERT     = 3'd4,
    ACT_DELETE     = 3'd5,
    ACT_READ       = 3'd6,
    ACT_FIND       = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // what the row of cells does with its entries when it is clocked
  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_INS  = 2'd1,
    SH_DEL  = 2'd2
  } shift_e;

  localparam int unsigned ValueW = 64;
  localparam int unsigned PosW   = 5;
  localparam int unsigned CountW = 5;
  localparam int unsigned FoundW = 4;

endpackage

@@ hdl/isq_cell.sv @@
// one storage cell of the sequence: holds one entry, shifts toward either
// neighbor, and registers its own compare and select results; uses isq_pkg
module isq_cell
  import isq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX   = 0
) (
  input  logic                       clk_i,
  input  shift_e                     op_i,
  input  logic [$clog2(DEPTH)-1:0]   at_i,
  input  logic [$clog2(DEPTH+1)-1:0] count_i,
  input  logic [ValueW-1:0]          value_i,
  input  logic [ValueW-1:0]          left_i,
  input  logic [ValueW-1:0]          right_i,
  output logic [ValueW-1:0]          entry_o,
  output logic                       hit_o,
  output logic [ValueW-1:0]          pick_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] MyIdx  = IW'(IDX);
  localparam logic [CW-1:0] MyIdxC = CW'(IDX);

  logic [ValueW-1:0] entry_q, entry_d;
  logic              hit_q, hit_d;
  logic [ValueW-1:0] pick_q, pick_d;

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      SH_INS: begin
        if (MyIdx > at_i) begin
          entry_d = left_i;
        end else if (MyIdx == at_i) begin
          entry_d = value_i;
        end
      end
      SH_DEL: begin
        if (MyIdx >= at_i) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // only entries below the fill count take part in find; select depends on the position alone
  assign hit_d  = (MyIdxC < count_i) && (entry_q == value_i);
  assign pick_d = (MyIdx == at_i) ? entry_q : '0;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
    pick_q  <= pick_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;
  assign pick_o  = pick_q;

endmodule

@@ hdl/indexed_sequence_store_top.sv @@
// indexed sequence store: an ordered row of DEPTH 64-bit entries in shifting cells
// an accepted item passes the registered compare and select in the cells (S_CMP), then
// the priority pick and shift that update the row (S_FIN), whose result is registered
// once the output can take it; a new item is accepted only back in S_IDLE
// reset: fill count clears to zero at once; entries are not cleared and are never read
// before they are written; depends on isq_pkg and isq_cell
module indexed_sequence_store_top
  import isq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // action [2:0], position [7:3], item_value [71:8]
  input  logic [71:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_out [63:0], count_out [68:64], found_index [72:69], status [75:73], zero [79:76]
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_FIN
  } state_e;

  state_e            state_q;
  logic [2:0]        act_q;
  logic [PosW-1:0]   pos_q;
  logic [ValueW-1:0] val_q;
  logic [CW-1:0]     count_q, count_d;

  logic [ValueW-1:0] data_out_q, data_out_d;
  logic [CountW-1:0] count_out_d;
  logic [CountW-1:0] count_out_q;
  logic [FoundW-1:0] found_q, found_d;
  status_e           status_q, status_d;
  logic              out_valid_q;

  logic              in_fire, fin_fire;
  shift_e            op_dec, cell_op;
  logic [IW-1:0]     at_dec;
  logic              take_data;

  logic [ValueW-1:0] entries [DEPTH];
  logic [DEPTH-1:0]  hits;
  logic [ValueW-1:0] picks [DEPTH];
  logic [ValueW-1:0] pick_or;
  logic [IW-1:0]     first_hit;
  logic              any_hit;

  logic              full, empty;
  logic [31:0]       pos_w, cnt_w;
  logic [CW-1:0]     last_idx;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign fin_fire = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == S_IDLE);

  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign pos_w    = 32'(pos_q);
  assign cnt_w    = 32'(count_q);
  assign last_idx = count_q - CW'(1);

  // decode the held item against the current fill count
  always_comb begin
    op_dec    = SH_HOLD;
    at_dec    = '0;
    status_d  = ST_OK;
    take_data = 1'b0;
    case (action_e'(act_q))
      ACT_PUSH_BACK: begin
        at_dec = count_q[IW-1:0];
        if (full) status_d = ST_FULL;
        else op_dec = SH_INS;
      end
      ACT_POP_BACK: begin
        at_dec = last_idx[IW-1:0];
        if (empty) status_d = ST_EMPTY;
        else begin
          op_dec    = SH_DEL;
          take_data = 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (full) status_d = ST_FULL;
        else op_dec = SH_INS;
      end
      ACT_POP_FRONT: begin
        if (empty) status_d = ST_EMPTY;
        else begin
          op_dec    = SH_DEL;
          take_data = 1'b1;
        end
      end
      ACT_INSERT: begin
        at_dec = IW'(pos_q);
        if (pos_w > cnt_w) status_d = ST_RANGE;
        else if (full) status_d = ST_FULL;
        else op_dec = SH_INS;
      end
      ACT_DELETE: begin
        at_dec = IW'(pos_q);
        if (pos_w >= cnt_w) status_d = ST_RANGE;
        else begin
          op_dec    = SH_DEL;
          take_data = 1'b1;
        end
      end
      ACT_READ: begin
        at_dec = IW'(pos_q);
        if (pos_w >= cnt_w) status_d = ST_RANGE;
        else take_data = 1'b1;
      end
      ACT_FIND: begin
        status_d = any_hit ? ST_OK : ST_NOTFOUND;
      end
      default: status_d = ST_OK;
    endcase
  end

  assign cell_op = fin_fire ? op_dec : SH_HOLD;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [ValueW-1:0] left_w, right_w;
      if (gi == 0) begin : g_first
        assign left_w = val_q;
      end else begin : g_mid_l
        assign left_w = entries[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_w = entries[gi];
      end else begin : g_mid_r
        assign right_w = entries[gi+1];
      end
      isq_cell #(
        .DEPTH (DEPTH),
        .IDX   (gi)
      ) u_cell (
        .clk_i   (clk_i),
        .op_i    (cell_op),
        .at_i    (at_dec),
        .count_i (count_q),
        .value_i (val_q),
        .left_i  (left_w),
        .right_i (right_w),
        .entry_o (entries[gi]),
        .hit_o   (hits[gi]),
        .pick_o  (picks[gi])
      );
    end
  endgenerate

  // merge the registered per-cell results
  always_comb begin
    pick_or   = '0;
    first_hit = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pick_or = pick_or | picks[i];
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) first_hit = IW'(i);
    end
  end
  assign any_hit = |hits;

  always_comb begin
    count_d = count_q;
    case (op_dec)
      SH_INS:  count_d = count_q + CW'(1);
      SH_DEL:  count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  assign data_out_d  = take_data ? pick_or : '0;
  assign found_d     = ((action_e'(act_q) == ACT_FIND) && any_hit) ?
                       FoundW'(32'(first_hit)) : '0;
  assign count_out_d = CountW'(32'(count_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      act_q       <= '0;
      pos_q       <= '0;
      val_q       <= '0;
      data_out_q  <= '0;
      count_out_q <= '0;
      found_q     <= '0;
      status_q    <= ST_OK;
    end else begin
      if (out_valid_q && m_axis_tready && !fin_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            act_q   <= s_axis_tdata[2:0];
            pos_q   <= s_axis_tdata[7:3];
            val_q   <= s_axis_tdata[71:8];
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (fin_fire) begin
            count_q     <= count_d;
            data_out_q  <= data_out_d;
            count_out_q <= count_out_d;
            found_q     <= found_d;
            status_q    <= status_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, status_q, found_q, count_out_q, data_out_q};

endmodule

@@ verif/tb_indexed_sequence_store_top.sv @@
// testbench for indexed_sequence_store_top: directed and random actions on the stream input,
// each result checked against a local sequence predictor; depends on isq_pkg and the top
module tb_indexed_sequence_store_top;
  import isq_pkg::*;

  localparam int unsigned SEQ_DEPTH = 16;
  localparam int unsigned NUM_ITEMS = 850;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    action_e       act;
    logic [4:0]    pos;
    logic [63:0]   val;
  } seq_item_t;

  typedef struct packed {
    logic [63:0] data;
    logic [4:0]  cnt;
    logic [3:0]  found;
    status_e     status;
  } seq_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [71:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  indexed_sequence_store_top #(
    .DEPTH(SEQ_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  seq_item_t   pending_items[$];
  seq_result_t expected_results[$];
  seq_result_t want;
  logic [63:0] seq_vals[SEQ_DEPTH];
  int unsigned seq_len = 0;
  logic [63:0] value_pool[8];
  int unsigned err_count = 0;
  int unsigned sent_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned cycle_cnt = 0;

  // shift entries up from position at and store v there
  function automatic void make_room(int unsigned at, logic [63:0] v);
    for (int unsigned i = seq_len; i > at; i--) seq_vals[i] = seq_vals[i - 1];
    seq_vals[at] = v;
    seq_len++;
  endfunction

  // remove the entry at position at and close the gap
  function automatic logic [63:0] take_out(int unsigned at);
    logic [63:0] v;
    v = seq_vals[at];
    for (int unsigned i = at; i + 1 < seq_len; i++) seq_vals[i] = seq_vals[i + 1];
    seq_len--;
    return v;
  endfunction

  function automatic seq_result_t seq_apply(seq_item_t it);
    seq_result_t r;
    r = '0;
    r.status = ST_OK;
    case (it.act)
      ACT_PUSH_BACK: begin
        if (seq_len >= SEQ_DEPTH) r.status = ST_FULL;
        else make_room(seq_len, it.val);
      end
      ACT_PUSH_FRONT: begin
        if (seq_len >= SEQ_DEPTH) r.status = ST_FULL;
        else make_room(0, it.val);
      end
      ACT_INSERT: begin
        // range check wins over the full check
        if (it.pos > seq_len) r.status = ST_RANGE;
        else if (seq_len >= SEQ_DEPTH) r.status = ST_FULL;
        else make_room(it.pos, it.val);
      end
      ACT_POP_BACK: begin
        if (seq_len == 0) r.status = ST_EMPTY;
        else r.data = take_out(seq_len - 1);
      end
      ACT_POP_FRONT: begin
        if (seq_len == 0) r.status = ST_EMPTY;
        else r.data = take_out(0);
      end
      ACT_DELETE: begin
        if (it.pos >= seq_len) r.status = ST_RANGE;
        else r.data = take_out(it.pos);
      end
      ACT_READ: begin
        if (it.pos >= seq_len) r.status = ST_RANGE;
        else r.data = seq_vals[it.pos];
      end
      default: begin
        r.status = ST_NOTFOUND;
        for (int unsigned i = 0; i < seq_len; i++) begin
          if (seq_vals[i] == it.val) begin
            r.found = i[3:0];
            r.status = ST_OK;
            break;
          end
        end
      end
    endcase
    r.cnt = seq_len[4:0];
    return r;
  endfunction

  function automatic void queue_item(action_e act, int unsigned pos, logic [63:0] val);
    seq_item_t it;
    it.act = act;
    it.pos = pos[4:0];
    it.val = val;
    pending_items.push_back(it);
  endfunction

  function automatic logic [63:0] pick_value();
    if ($urandom_range(9) < 5) return value_pool[$urandom_range(7)];
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_pos();
    if ($urandom_range(1) == 0) return $urandom_range(7);
    return $urandom_range(16);
  endfunction

  function automatic void queue_add();
    case ($urandom_range(2))
      0: queue_item(ACT_PUSH_BACK, pick_pos(), pick_value());
      1: queue_item(ACT_PUSH_FRONT, pick_pos(), pick_value());
      default: queue_item(ACT_INSERT, pick_pos(), pick_value());
    endcase
  endfunction

  function automatic void queue_remove();
    case ($urandom_range(2))
      0: queue_item(ACT_POP_BACK, pick_pos(), pick_value());
      1: queue_item(ACT_POP_FRONT, pick_pos(), pick_value());
      default: queue_item(ACT_DELETE, pick_pos(), pick_value());
    endcase
  endfunction

  function automatic void queue_lookup();
    if ($urandom_range(1) == 0) queue_item(ACT_READ, pick_pos(), pick_value());
    else queue_item(ACT_FIND, pick_pos(), pick_value());
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      err_count++;
    end
  endtask

  // sender: holds an offered item until taken, predicts at acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        expected_results.push_back(seq_apply(pending_items.pop_front()));
        sent_cnt <= sent_cnt + 1;
      end
      if (pending_items.size() != 0 &&
          ((sent_cnt >= 450 && sent_cnt < 600) || $urandom_range(99) >= 23)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_items[0].val, pending_items[0].pos, pending_items[0].act};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off so the input backs up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && got_cnt >= 250) begin
      hold_left     <= 200;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (got_cnt >= 450 && got_cnt < 600) || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: %0h", m_axis_tdata);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("data_out", want.data, m_axis_tdata[63:0]);
        check_field("count_out", 64'(want.cnt), 64'(m_axis_tdata[68:64]));
        check_field("found_index", 64'(want.found), 64'(m_axis_tdata[72:69]));
        check_field("status", 64'(want.status), 64'(m_axis_tdata[75:73]));
        check_field("pad", 64'd0, 64'(m_axis_tdata[79:76]));
      end
      got_cnt <= got_cnt + 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned kind;
    int unsigned burst;
    int unsigned r;

    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 8; i++) value_pool[i] = {$urandom, $urandom};

    // empty sequence: every removal, lookup and bad insert, then fill with three adds
    queue_item(ACT_POP_BACK, 0, '0);
    queue_item(ACT_POP_FRONT, 0, '0);
    queue_item(ACT_DELETE, 0, '0);
    queue_item(ACT_READ, 16, '0);
    queue_item(ACT_FIND, 0, '0);
    queue_item(ACT_INSERT, 1, value_pool[2]);
    queue_item(ACT_INSERT, 0, '0);
    queue_item(ACT_PUSH_FRONT, 31, '1);
    queue_item(ACT_PUSH_BACK, 0, value_pool[2]);
    // position equal to count appends
    queue_item(ACT_INSERT, 3, value_pool[3]);
    queue_item(ACT_INSERT, 1, value_pool[2]);
    queue_item(ACT_READ, 4, '0);
    // duplicate target: first index wins
    queue_item(ACT_FIND, 0, value_pool[2]);
    queue_item(ACT_FIND, 0, value_pool[4]);
    queue_item(ACT_READ, 5, '0);
    queue_item(ACT_DELETE, 5, '0);
    queue_item(ACT_DELETE, 2, '0);
    queue_item(ACT_POP_BACK, 0, '0);
    queue_item(ACT_POP_FRONT, 0, '0);
    queue_item(ACT_INSERT, 16, '1);
    queue_item(ACT_PUSH_BACK, 0, {$urandom, $urandom});

    // random bursts biased to grow, shrink or look up, plus plain noise
    while (pending_items.size() < NUM_ITEMS) begin
      kind  = $urandom_range(9);
      burst = $urandom_range(4, 24);
      for (int unsigned n = 0; n < burst; n++) begin
        r = $urandom_range(9);
        if (kind < 3) begin
          if (r < 7) queue_add();
          else if (r < 9) queue_lookup();
          else queue_remove();
        end else if (kind < 6) begin
          if (r < 7) queue_remove();
          else if (r < 9) queue_lookup();
          else queue_add();
        end else if (kind < 8) begin
          if (r < 8) queue_lookup();
          else if (r == 8) queue_add();
          else queue_remove();
        end else begin
          queue_item(action_e'($urandom_range(7)), $urandom_range(16), pick_value());
        end
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
